FILE: src/iufp_pkg.sv
// ----------------------------------------------------------------------------
// iufp_pkg
// Shared types and constants for the serial IMU frame parser.
// ----------------------------------------------------------------------------
package iufp_pkg;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_FIRST = 8'h51;
  localparam logic [7:0] TYPE_LAST  = 8'h54;
  localparam int         FRAME_BYTES = 11;
  localparam int         STORE_DEPTH = 10;

  localparam logic [3:0] POS_IDLE = 4'd0;
  localparam logic [3:0] POS_TYPE = 4'd1;
  localparam logic [3:0] POS_CSUM = 4'(STORE_DEPTH);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CSUM_ERR = 2'd1;
  localparam logic [1:0] ST_BAD_TYPE = 2'd2;

  // one frame byte as classified by the front end
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] pos;      // byte position in the frame, 1..10
    logic       last;     // checksum byte, closes the frame
    logic       csum_ok;  // valid with last
  } tok_t;

endpackage

FILE: src/iufp_front.sv
// ----------------------------------------------------------------------------
// iufp_front
// Frame tracker: hunts for the header, counts frame bytes, keeps the running
// sum and tags each frame byte for the back end.
// ----------------------------------------------------------------------------
module iufp_front import iufp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       tok_push,
  output tok_t       tok
);

  logic [3:0] byte_count;
  logic [3:0] byte_count_next;
  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic       in_frame;

  assign in_frame = (byte_count != POS_IDLE) && (byte_count < 4'(FRAME_BYTES));

  always_comb begin
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    tok_push         = 1'b0;
    tok.data         = rx_byte;
    tok.pos          = byte_count;
    tok.last         = (byte_count == POS_CSUM);
    tok.csum_ok      = (running_sum == rx_byte);
    if (accept) begin
      if (!in_frame) begin
        // header byte is not stored, only summed
        if (rx_byte == HDR_BYTE) begin
          byte_count_next  = POS_TYPE;
          running_sum_next = rx_byte;
        end else begin
          byte_count_next  = POS_IDLE;
        end
      end else if (byte_count == POS_CSUM) begin
        tok_push         = 1'b1;
        byte_count_next  = POS_IDLE;
        running_sum_next = 8'd0;
      end else begin
        tok_push         = 1'b1;
        byte_count_next  = byte_count + 4'd1;
        running_sum_next = running_sum + rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= POS_IDLE;
      running_sum <= 8'd0;
    end else begin
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
    end
  end

endmodule

FILE: src/iufp_queue.sv
// ----------------------------------------------------------------------------
// iufp_queue
// Short token queue between front and back end.
// ----------------------------------------------------------------------------
module iufp_queue import iufp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  tok_t wr_tok,
  input  logic rd_en,
  output tok_t rd_tok,
  output logic full,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tok_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_tok = slots[rd_ptr];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_rd) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: src/iufp_back.sv
// ----------------------------------------------------------------------------
// iufp_back
// Frame assembler: stores frame bytes, and on the checksum byte builds the
// result and holds it in the output register.
// ----------------------------------------------------------------------------
module iufp_back import iufp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               tok_valid,
  input  tok_t               tok,
  output logic               tok_take,
  input  logic               pop,
  output logic               empty,
  output logic        [7:0]  type_byte,
  output logic signed [15:0] word_x,
  output logic signed [15:0] word_y,
  output logic signed [15:0] word_z,
  output logic signed [15:0] word_extra,
  output logic        [1:0]  frame_status
);

  logic [7:0] frame_store [1:STORE_DEPTH-1];
  logic       out_valid;
  logic       out_free;
  logic [1:0] status;
  logic       type_bad;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  // data bytes never wait on the output register
  assign tok_take = tok_valid && (!tok.last || out_free);

  assign type_bad = (frame_store[1] < TYPE_FIRST) || (frame_store[1] > TYPE_LAST);

  always_comb begin
    if (!tok.csum_ok) begin
      status = ST_CSUM_ERR;
    end else if (type_bad) begin
      status = ST_BAD_TYPE;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 1; i < STORE_DEPTH; i++) begin
      if (tok_take && !tok.last && tok.pos == 4'(i)) begin
        frame_store[i] <= tok.data;
      end
    end
    if (tok_take && tok.last) begin
      type_byte    <= frame_store[1];
      word_x       <= {frame_store[3], frame_store[2]};
      word_y       <= {frame_store[5], frame_store[4]};
      word_z       <= {frame_store[7], frame_store[6]};
      word_extra   <= {frame_store[9], frame_store[8]};
      frame_status <= status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tok_take && tok.last) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: src/imu_uart_frame_parser.sv
// ----------------------------------------------------------------------------
// imu_uart_frame_parser
// 11-byte sum-checksum serial frame parser: header hunt, byte collection and
// one result per complete frame.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake        | Payload
// input   | in        | push / full      | rx_byte
// result  | out       | empty / pop      | type_byte, word_x..word_extra, frame_status
//
// One byte per cycle sustained while full stays low. The front end tracks the
// frame and sum as each byte is accepted; the back end stores bytes from the token
// queue. A result passes the token queue and then the registered result stage.
// A held result stalls only the checksum token; the queue (QUEUE_DEPTH
// tokens) keeps taking bytes until it fills, then full rises.
// Reset clears the frame tracker, the queue and the result valid flag.
module imu_uart_frame_parser import iufp_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic        [7:0]  rx_byte,
  output logic               empty,
  input  logic               pop,
  output logic        [7:0]  type_byte,
  output logic signed [15:0] word_x,
  output logic signed [15:0] word_y,
  output logic signed [15:0] word_z,
  output logic signed [15:0] word_extra,
  output logic        [1:0]  frame_status
);

  logic accept;
  logic tok_push;
  tok_t front_tok;
  tok_t back_tok;
  logic q_empty;
  logic tok_take;

  assign accept = push && !full;

  iufp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (rx_byte),
    .tok_push (tok_push),
    .tok      (front_tok)
  );

  iufp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (tok_push),
    .wr_tok (front_tok),
    .rd_en  (tok_take),
    .rd_tok (back_tok),
    .full   (full),
    .empty  (q_empty)
  );

  iufp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .tok_valid    (!q_empty),
    .tok          (back_tok),
    .tok_take     (tok_take),
    .pop          (pop),
    .empty        (empty),
    .type_byte    (type_byte),
    .word_x       (word_x),
    .word_y       (word_y),
    .word_z       (word_z),
    .word_extra   (word_extra),
    .frame_status (frame_status)
  );

endmodule

FILE: src/iufp_checker.sv
// ----------------------------------------------------------------------------
// iufp_checker
// Port-level checks for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module iufp_checker import iufp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  type_byte,
  input logic [15:0] word_x,
  input logic [1:0]  frame_status
);

  // reset leaves no result and room for input
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("result or full state survived reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (frame_status == ST_OK || frame_status == ST_CSUM_ERR ||
                frame_status == ST_BAD_TYPE))
    else $error("undefined frame status");

  // a result needs at least a byte through the queue after reset
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> !$past(rst, 1) && !$past(rst, 2))
    else $error("result appeared too soon after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(type_byte) && $stable(word_x) &&
                       $stable(frame_status))
    else $error("waiting result changed before transfer");

endmodule

bind imu_uart_frame_parser iufp_checker u_iufp_checker (
  .clk          (clk),
  .rst          (rst),
  .push         (push),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .type_byte    (type_byte),
  .word_x       (word_x),
  .frame_status (frame_status)
);

FILE: tb/tb_imu_uart_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_uart_frame_parser
// Streams serial bytes (noise, clean frames, truncated frames) into the frame
// parser and checks every decoded frame against an in-bench frame tracker.
// Sender gaps, receiver stalls and a long receiver hold-off vary by phase.
// ----------------------------------------------------------------------------
module tb_imu_uart_frame_parser;
  import iufp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic        [7:0]  type_byte;
    logic signed [15:0] word_x;
    logic signed [15:0] word_y;
    logic signed [15:0] word_z;
    logic signed [15:0] word_extra;
    logic        [1:0]  frame_status;
  } frame_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic        [7:0]  rx_byte = 8'h00;
  logic               pop = 1'b0;
  logic               full;
  logic               empty;
  logic        [7:0]  type_byte;
  logic signed [15:0] word_x;
  logic signed [15:0] word_y;
  logic signed [15:0] word_z;
  logic signed [15:0] word_extra;
  logic        [1:0]  frame_status;

  logic [7:0]    rx_feed[$];
  frame_result_t pending_frames[$];
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  logic          hold_req = 1'b0;
  int            hold_left = 0;
  int            error_count = 0;
  int unsigned   cycle_count = 0;

  // frame tracker state
  logic [3:0] frame_pos = POS_IDLE;
  logic [7:0] frame_bytes [STORE_DEPTH];
  logic [7:0] frame_sum = 8'h00;

  imu_uart_frame_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .rx_byte      (rx_byte),
    .empty        (empty),
    .pop          (pop),
    .type_byte    (type_byte),
    .word_x       (word_x),
    .word_y       (word_y),
    .word_z       (word_z),
    .word_extra   (word_extra),
    .frame_status (frame_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void log_error(string msg);
    if (error_count < 10) $display("[%0t] %s", $time, msg);
    error_count++;
  endfunction

  // Advance the frame tracker by one accepted byte.
  task automatic parse_byte(input logic [7:0] b);
    frame_result_t r;
    if (frame_pos == POS_IDLE) begin
      if (b == HDR_BYTE) begin
        frame_bytes[0] = b;
        frame_sum = b;
        frame_pos = POS_TYPE;
      end
    end else if (frame_pos < POS_CSUM) begin
      frame_bytes[frame_pos] = b;
      frame_sum = frame_sum + b;
      frame_pos = frame_pos + 4'd1;
    end else begin
      r.type_byte  = frame_bytes[1];
      r.word_x     = {frame_bytes[3], frame_bytes[2]};
      r.word_y     = {frame_bytes[5], frame_bytes[4]};
      r.word_z     = {frame_bytes[7], frame_bytes[6]};
      r.word_extra = {frame_bytes[9], frame_bytes[8]};
      if (frame_sum != b)
        r.frame_status = ST_CSUM_ERR;
      else if (frame_bytes[1] < TYPE_FIRST || frame_bytes[1] > TYPE_LAST)
        r.frame_status = ST_BAD_TYPE;
      else
        r.frame_status = ST_OK;
      pending_frames.push_back(r);
      frame_pos = POS_IDLE;
      frame_sum = 8'h00;
    end
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want)
      log_error($sformatf("%s mismatch: expected %h, got %h", name, want, got));
  endfunction

  task automatic check_frame();
    frame_result_t want;
    if (pending_frames.size() == 0) begin
      log_error($sformatf("unexpected frame: type %h status %0d", type_byte, frame_status));
      return;
    end
    want = pending_frames.pop_front();
    check_field("type_byte", 16'(want.type_byte), 16'(type_byte));
    check_field("word_x", want.word_x, word_x);
    check_field("word_y", want.word_y, word_y);
    check_field("word_z", want.word_z, word_z);
    check_field("word_extra", want.word_extra, word_extra);
    check_field("frame_status", 16'(want.frame_status), 16'(frame_status));
  endtask

  // byte source: hold the offered byte until the transfer happens
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) parse_byte(rx_byte);
      if (!push || !full) begin
        if (rx_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push <= 1'b1;
          rx_byte <= rx_feed.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result sink
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_frame();
      pop <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst)
      hold_left <= 0;
    else if (hold_req)
      hold_left <= HOLD_CYCLES;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] random_words();
    logic [63:0] w;
    w = {$urandom, $urandom};
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(7))
        0: w[16*i +: 16] = 16'h8000;
        1: w[16*i +: 16] = 16'h7FFF;
        default: ;
      endcase
    end
    return w;
  endfunction

  // Queue the first keep bytes of a frame; data holds bytes 2..9, low byte first.
  task automatic queue_frame(input logic [7:0] ftype, input logic [63:0] data,
                             input bit csum_good, input int keep);
    logic [7:0] fb [FRAME_BYTES];
    logic [7:0] s;
    fb[0] = HDR_BYTE;
    fb[1] = ftype;
    for (int i = 0; i < 8; i++) fb[i + 2] = data[8*i +: 8];
    s = 8'h00;
    for (int i = 0; i < STORE_DEPTH; i++) s = s + fb[i];
    fb[STORE_DEPTH] = csum_good ? s : s ^ 8'(1 + $urandom_range(254));
    for (int i = 0; i < keep; i++) rx_feed.push_back(fb[i]);
  endtask

  function automatic logic [7:0] random_type();
    if ($urandom_range(99) < 80) return 8'(TYPE_FIRST + $urandom_range(3));
    return 8'($urandom_range(255));
  endfunction

  // mostly clean frames, with line noise and cut-off frames mixed in
  task automatic queue_random(input int n_bytes);
    int pick;
    int n;
    while (rx_feed.size() < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        queue_frame(random_type(), random_words(), $urandom_range(99) < 85, FRAME_BYTES);
      end else if (pick < 87) begin
        n = $urandom_range(1, 4);
        repeat (n) rx_feed.push_back(8'($urandom_range(255)));
      end else begin
        queue_frame(random_type(), random_words(), 1'b1, $urandom_range(2, STORE_DEPTH));
      end
    end
  endtask

  task automatic drain_feed();
    while (rx_feed.size() != 0 || push) @(negedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_bytes);
    @(negedge clk);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    queue_random(n_bytes);
    drain_feed();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: noise while idle, extreme words with a header byte inside
    // the frame, a bad checksum, and an unknown type with a good checksum
    @(negedge clk);
    rx_feed.push_back(8'h00);
    rx_feed.push_back(8'hFF);
    queue_frame(TYPE_FIRST, 64'hFFFF_0055_8000_7FFF, 1'b1, FRAME_BYTES);
    queue_frame(TYPE_LAST, 64'h0000_0000_0000_0000, 1'b0, FRAME_BYTES);
    queue_frame(8'h50, 64'h0123_4567_89AB_CDEF, 1'b1, FRAME_BYTES);
    drain_feed();

    run_phase(0, 0, 320);
    run_phase(81, 0, 320);
    run_phase(0, 81, 320);
    run_phase(31, 31, 320);

    // receiver holds off while clean frames keep arriving, so full must rise
    @(negedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    repeat (20) queue_frame(8'(TYPE_FIRST + $urandom_range(3)), random_words(), 1'b1,
                            FRAME_BYTES);
    @(negedge clk);
    hold_req = 1'b0;
    drain_feed();

    while (pending_frames.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_frames.size() != 0)
      log_error($sformatf("%0d frames never arrived", pending_frames.size()));

    if (error_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
